// ===== design/prm_pkg.sv =====
// shared types, constants and state encodings for the peak region merger
package prm_pkg;

  localparam int unsigned MAX_REGIONS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 4;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned DIM_W      = 13;
  localparam int unsigned PEAK_W     = 16;
  localparam int unsigned SCORE_W    = 16;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned SCALE_W    = 17;
  localparam int unsigned REGCNT_W   = 5;
  localparam int unsigned BUDGET_W   = 25;
  localparam int unsigned AREA_W     = 26;
  localparam int unsigned ID_W       = 4;
  localparam int unsigned UNIT_SHIFT = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 25;

  localparam logic [DIM_W-1:0]   MIN_ROI   = 13'd16;
  localparam logic [DIM_W-1:0]   MAX_DIM   = 13'd4096;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
  localparam logic               REQ_FLUSH = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE     = 3'd0,
    CFG_ROI_W     = 3'd1,
    CFG_ROI_H     = 3'd2,
    CFG_IMG_W     = 3'd3,
    CFG_IMG_H     = 3'd4,
    CFG_MAX_REG   = 3'd5,
    CFG_MAX_PIX   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [SCALE_W-1:0]  scale_q16;
    logic [DIM_W-1:0]    roi_width;
    logic [DIM_W-1:0]    roi_height;
    logic [DIM_W-1:0]    image_width;
    logic [DIM_W-1:0]    image_height;
    logic [REGCNT_W-1:0] max_regions;
    logic [BUDGET_W-1:0] max_total_pixels;
  } cfg_t;

  typedef struct packed {
    logic               req_type;
    logic [PEAK_W-1:0]  peak_x;
    logic [PEAK_W-1:0]  peak_y;
    logic [SCORE_W-1:0] peak_score;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    region_id;
    logic [DIM_W-1:0]   box_x;
    logic [DIM_W-1:0]   box_y;
    logic [DIM_W-1:0]   box_w;
    logic [DIM_W-1:0]   box_h;
    logic [DIM_W-1:0]   resp_x;
    logic [DIM_W-1:0]   resp_y;
    logic [DIM_W-1:0]   resp_w;
    logic [DIM_W-1:0]   resp_h;
    logic [SCORE_W-1:0] best_score;
    logic [COUNT_W-1:0] peak_count;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } box_t;

  typedef struct packed {
    logic               is_flush;
    box_t               box;
    logic [SCORE_W-1:0] score;
  } cmd_t;

  typedef struct packed {
    box_t               l0;
    box_t               resp;
    logic [SCORE_W-1:0] score;
    logic [COUNT_W-1:0] count;
  } region_t;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL, F_PREP, F_DIV, F_CLIP, F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE, B_AREA, B_RD, B_CMP, B_DEC, B_APP, B_WR, B_ERD, B_EMIT
  } back_state_e;

endpackage

// ===== design/prm_front.sv =====
// front end: accepts items, places and clips the box of a peak
module prm_front import prm_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  output logic     push_o,
  output cmd_t     cmd_o,
  input  logic     q_full_i
);

  localparam int unsigned DW   = SCALE_W + FRAC_BITS;
  localparam int unsigned PW   = DIM_W + DW;
  localparam int unsigned AW   = PEAK_W + UNIT_SHIFT;
  localparam int unsigned MW   = (AW > PW) ? AW : PW;
  localparam int unsigned NQ   = MW + 1;
  localparam int unsigned RW   = DW + 1;
  localparam int unsigned EW   = NQ + 2;
  localparam int unsigned CNTW = $clog2(NQ + 1);

  front_state_e    state_q, state_d;
  in_item_t        req_q, req_d;
  cmd_t            cmd_q, cmd_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [PW-1:0]   prod_q [2];
  logic [PW-1:0]   prod_d [2];
  logic [NQ-1:0]   quo_q [2];
  logic [NQ-1:0]   quo_d [2];
  logic [RW-1:0]   rem_q [2];
  logic [RW-1:0]   rem_d [2];
  logic            neg_q [2];
  logic            neg_d [2];

  logic [SCALE_W-1:0] s_eff;
  logic [DW-1:0]      d_val;
  logic [RW-1:0]      div_val;
  logic [DIM_W-1:0]   size_l [2];
  logic [DIM_W-1:0]   lim_l [2];
  logic [PEAK_W-1:0]  pos_l [2];
  logic [NQ-1:0]      num_l [2];
  logic               ge_l [2];
  logic [RW-1:0]      rem_n [2];
  logic [NQ-1:0]      quo_n [2];
  logic [DIM_W-1:0]   lo_l [2];
  logic [DIM_W-1:0]   hi_l [2];

  function automatic logic [DIM_W-1:0] clip(input logic signed [EW-1:0] v,
                                            input logic [DIM_W-1:0] lim);
    logic signed [EW-1:0] l;
    l = $signed(EW'(lim));
    if (v < 0) return '0;
    else if (v > l) return lim;
    else return v[DIM_W-1:0];
  endfunction

  function automatic logic [DIM_W-1:0] roi_eff(input logic [DIM_W-1:0] v);
    if (v < MIN_ROI) return MIN_ROI;
    else if (v > MAX_DIM) return MAX_DIM;
    else return v;
  endfunction

  assign s_eff   = (cfg_i.scale_q16 == '0) ? SCALE_W'(1) : cfg_i.scale_q16;
  assign d_val   = DW'(s_eff) << FRAC_BITS;
  assign div_val = {d_val, 1'b0};

  assign size_l[0] = roi_eff(cfg_i.roi_width);
  assign size_l[1] = roi_eff(cfg_i.roi_height);
  assign lim_l[0]  = (cfg_i.image_width > MAX_DIM) ? MAX_DIM : cfg_i.image_width;
  assign lim_l[1]  = (cfg_i.image_height > MAX_DIM) ? MAX_DIM : cfg_i.image_height;
  assign pos_l[0]  = req_q.peak_x;
  assign pos_l[1]  = req_q.peak_y;

  always_comb begin
    logic [MW-1:0]        a_v, b_v, mag_v;
    logic [RW:0]          trial_v;
    logic                 ok_v;
    logic signed [EW-1:0] e_v;
    for (int k = 0; k < 2; k++) begin
      a_v      = MW'(pos_l[k]) << UNIT_SHIFT;
      b_v      = MW'(prod_q[k]);
      ge_l[k]  = (a_v >= b_v);
      mag_v    = ge_l[k] ? (a_v - b_v) : (b_v - a_v);
      num_l[k] = NQ'(mag_v) + NQ'(d_val);
      trial_v  = {rem_q[k], quo_q[k][NQ-1]};
      ok_v     = (trial_v >= {1'b0, div_val});
      rem_n[k] = ok_v ? RW'(trial_v - {1'b0, div_val}) : RW'(trial_v);
      quo_n[k] = {quo_q[k][NQ-2:0], ok_v};
      e_v      = neg_q[k] ? -$signed(EW'(quo_q[k])) : $signed(EW'(quo_q[k]));
      lo_l[k]  = clip(e_v, lim_l[k]);
      hi_l[k]  = clip(e_v + $signed(EW'(size_l[k])), lim_l[k]);
    end
  end

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    cmd_d   = cmd_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          req_d          = in_data_i;
          cmd_d.is_flush = (in_data_i.req_type == REQ_FLUSH);
          cmd_d.score    = in_data_i.peak_score;
          state_d        = (in_data_i.req_type == REQ_FLUSH) ? F_PUSH : F_MUL;
        end
      end
      F_MUL: begin
        for (int k = 0; k < 2; k++) prod_d[k] = PW'(size_l[k]) * PW'(d_val);
        state_d = F_PREP;
      end
      F_PREP: begin
        for (int k = 0; k < 2; k++) begin
          quo_d[k] = num_l[k];
          rem_d[k] = '0;
          neg_d[k] = !ge_l[k];
        end
        cnt_d   = CNTW'(NQ);
        state_d = F_DIV;
      end
      F_DIV: begin
        quo_d = quo_n;
        rem_d = rem_n;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) state_d = F_CLIP;
      end
      F_CLIP: begin
        cmd_d.box.x = lo_l[0];
        cmd_d.box.y = lo_l[1];
        cmd_d.box.w = hi_l[0] - lo_l[0];
        cmd_d.box.h = hi_l[1] - lo_l[1];
        state_d = (hi_l[0] > lo_l[0] && hi_l[1] > lo_l[1]) ? F_PUSH : F_IDLE;
      end
      F_PUSH: begin
        if (!q_full_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != F_IDLE);
  assign push_o     = (state_q == F_PUSH) && !q_full_i;
  assign cmd_o      = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    cmd_q  <= cmd_d;
    cnt_q  <= cnt_d;
    prod_q <= prod_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
  end

endmodule

// ===== design/prm_queue.sv =====
// small command queue between the front and back ends
module prm_queue import prm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  localparam int unsigned PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PTRW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNTW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// ===== design/prm_back.sv =====
// back end: region table scan, merge, append and flush output
module prm_back import prm_pkg::*; #(
  parameter int unsigned MAX_REGIONS = MAX_REGIONS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_empty_i,
  input  cmd_t      q_data_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned LW = (CW > REGCNT_W) ? CW : REGCNT_W;
  localparam int unsigned RPW = DIM_W + SCALE_W;

  back_state_e       state_q, state_d;
  cmd_t              cur_q, cur_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     used_q, used_d;
  logic [BUDGET_W-1:0] pix_q, pix_d;
  logic [AREA_W-1:0] ba_q, ba_d, ia_q, ia_d, ra_q, ra_d;
  logic [RPW-1:0]    rp_q [4];
  logic [RPW-1:0]    rp_d [4];
  out_item_t         out_q, out_d;
  logic              ov_q, ov_d;

  region_t           mem_q [MAX_REGIONS];
  region_t           rd_q;
  logic              we;
  logic [IW-1:0]     wa;
  region_t           wd;

  logic [SCALE_W-1:0] s_eff;
  logic [LW-1:0]      lim;
  logic               out_free;
  logic               idx_last;
  logic [DIM_W:0]     ix1, ix2, iy1, iy2;
  logic [DIM_W:0]     ux2, uy2;
  logic [DIM_W-1:0]   ux1, uy1;
  logic [AREA_W-1:0]  m_area;
  logic               hit;
  logic [DIM_W-1:0]   resp_v [4];

  assign s_eff    = (cfg_i.scale_q16 == '0) ? SCALE_W'(1) : cfg_i.scale_q16;
  assign lim      = (LW'(cfg_i.max_regions) > LW'(MAX_REGIONS)) ? LW'(MAX_REGIONS)
                                                                 : LW'(cfg_i.max_regions);
  assign out_free = !ov_q || !out_stall_i;
  assign idx_last = ((CW'(idx_q) + 1'b1) == used_q);

  // intersection and union against the stored region
  always_comb begin
    logic [DIM_W:0] rx2, ry2, bx2, by2;
    rx2 = (DIM_W+1)'(rd_q.l0.x) + (DIM_W+1)'(rd_q.l0.w);
    ry2 = (DIM_W+1)'(rd_q.l0.y) + (DIM_W+1)'(rd_q.l0.h);
    bx2 = (DIM_W+1)'(cur_q.box.x) + (DIM_W+1)'(cur_q.box.w);
    by2 = (DIM_W+1)'(cur_q.box.y) + (DIM_W+1)'(cur_q.box.h);
    ix1 = (rd_q.l0.x > cur_q.box.x) ? (DIM_W+1)'(rd_q.l0.x) : (DIM_W+1)'(cur_q.box.x);
    iy1 = (rd_q.l0.y > cur_q.box.y) ? (DIM_W+1)'(rd_q.l0.y) : (DIM_W+1)'(cur_q.box.y);
    ix2 = (rx2 < bx2) ? rx2 : bx2;
    iy2 = (ry2 < by2) ? ry2 : by2;
    ux1 = (rd_q.l0.x < cur_q.box.x) ? rd_q.l0.x : cur_q.box.x;
    uy1 = (rd_q.l0.y < cur_q.box.y) ? rd_q.l0.y : cur_q.box.y;
    ux2 = (rx2 > bx2) ? rx2 : bx2;
    uy2 = (ry2 > by2) ? ry2 : by2;
  end

  always_comb begin
    logic [AREA_W+4:0] lhs, rhs;
    m_area = (ra_q < ba_q) ? ra_q : ba_q;
    if (m_area == '0) m_area = AREA_W'(1);
    lhs = ((AREA_W+5)'(ia_q) << 4) + ((AREA_W+5)'(ia_q) << 2);
    rhs = ((AREA_W+5)'(m_area) << 3) - (AREA_W+5)'(m_area);
    hit = (ia_q != '0) && (lhs > rhs);
  end

  always_comb begin
    logic [RPW:0] r;
    for (int k = 0; k < 4; k++) begin
      r = (RPW+1)'(rp_q[k]) + (RPW+1)'(32768);
      resp_v[k] = ((r >> 16) > (RPW+1)'(MAX_DIM)) ? MAX_DIM : DIM_W'(r >> 16);
    end
  end

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    idx_d   = idx_q;
    used_d  = used_q;
    pix_d   = pix_q;
    ba_d    = ba_q;
    ia_d    = ia_q;
    ra_d    = ra_q;
    rp_d    = rp_q;
    out_d   = out_q;
    ov_d    = ov_q && out_stall_i;
    pop_o   = 1'b0;
    we      = 1'b0;
    wa      = idx_q;
    wd      = rd_q;
    unique case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          cur_d = q_data_i;
          idx_d = '0;
          if (q_data_i.is_flush) begin
            if (used_q != '0) state_d = B_ERD;
          end else if (LW'(used_q) < lim) begin
            state_d = B_AREA;
          end
        end
      end
      B_AREA: begin
        ba_d    = AREA_W'(cur_q.box.w) * AREA_W'(cur_q.box.h);
        state_d = (used_q == '0) ? B_APP : B_RD;
      end
      B_RD: state_d = B_CMP;
      B_CMP: begin
        ia_d = (ix2 > ix1 && iy2 > iy1) ? AREA_W'(ix2 - ix1) * AREA_W'(iy2 - iy1) : '0;
        ra_d = AREA_W'(rd_q.l0.w) * AREA_W'(rd_q.l0.h);
        state_d = B_DEC;
      end
      B_DEC: begin
        if (hit) begin
          we       = 1'b1;
          wd.l0.x  = ux1;
          wd.l0.y  = uy1;
          wd.l0.w  = DIM_W'(ux2 - (DIM_W+1)'(ux1));
          wd.l0.h  = DIM_W'(uy2 - (DIM_W+1)'(uy1));
          wd.count = (rd_q.count == COUNT_MAX) ? COUNT_MAX : rd_q.count + 1'b1;
          wd.score = (cur_q.score > rd_q.score) ? cur_q.score : rd_q.score;
          state_d  = B_IDLE;
        end else if (idx_last) begin
          state_d = B_APP;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = B_RD;
        end
      end
      B_APP: begin
        if ((AREA_W'(pix_q) + ba_q) > AREA_W'(cfg_i.max_total_pixels)) begin
          state_d = B_IDLE;
        end else begin
          rp_d[0] = RPW'(cur_q.box.x) * RPW'(s_eff);
          rp_d[1] = RPW'(cur_q.box.y) * RPW'(s_eff);
          rp_d[2] = RPW'(cur_q.box.w) * RPW'(s_eff);
          rp_d[3] = RPW'(cur_q.box.h) * RPW'(s_eff);
          state_d = B_WR;
        end
      end
      B_WR: begin
        we          = 1'b1;
        wa          = used_q[IW-1:0];
        wd.l0       = cur_q.box;
        wd.resp.x   = resp_v[0];
        wd.resp.y   = resp_v[1];
        wd.resp.w   = resp_v[2];
        wd.resp.h   = resp_v[3];
        wd.score    = cur_q.score;
        wd.count    = COUNT_W'(1);
        used_d      = used_q + 1'b1;
        pix_d       = BUDGET_W'(AREA_W'(pix_q) + ba_q);
        state_d     = B_IDLE;
      end
      B_ERD: state_d = B_EMIT;
      B_EMIT: begin
        if (out_free) begin
          ov_d             = 1'b1;
          out_d.region_id  = ID_W'(idx_q);
          out_d.box_x      = rd_q.l0.x;
          out_d.box_y      = rd_q.l0.y;
          out_d.box_w      = rd_q.l0.w;
          out_d.box_h      = rd_q.l0.h;
          out_d.resp_x     = rd_q.resp.x;
          out_d.resp_y     = rd_q.resp.y;
          out_d.resp_w     = rd_q.resp.w;
          out_d.resp_h     = rd_q.resp.h;
          out_d.best_score = rd_q.score;
          out_d.peak_count = rd_q.count;
          out_d.last       = idx_last;
          if (idx_last) begin
            used_d  = '0;
            pix_d   = '0;
            state_d = B_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = B_ERD;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      used_q  <= '0;
      pix_q   <= '0;
      ov_q    <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      pix_q   <= pix_d;
      ov_q    <= ov_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    ba_q  <= ba_d;
    ia_q  <= ia_d;
    ra_q  <= ra_d;
    rp_q  <= rp_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[idx_q];
  end

endmodule

// ===== design/peak_region_merger.sv =====
// top level of the peak region merger: config registers, front, queue and back
// a peak passes the front's multiply, prepare, divide, clip and push states; the two-lane
// restoring divider yields one quotient bit per cycle; the back then scans each stored region
// via read, compare and decide; a flush emits each region via the registered table read
// front and back overlap through a two-entry queue, so a flush can stream while peaks wait
// reset clears control state and the region count at once; table entries are not cleared
module peak_region_merger import prm_pkg::*; #(
  parameter int unsigned MAX_REGIONS = MAX_REGIONS_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q;
  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale_q16        <= SCALE_W'(65536);
      cfg_q.roi_width        <= MIN_ROI;
      cfg_q.roi_height       <= MIN_ROI;
      cfg_q.image_width      <= '0;
      cfg_q.image_height     <= '0;
      cfg_q.max_regions      <= '0;
      cfg_q.max_total_pixels <= BUDGET_W'(16777216);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCALE:   cfg_q.scale_q16        <= cfg_data_i[SCALE_W-1:0];
        CFG_ROI_W:   cfg_q.roi_width        <= cfg_data_i[DIM_W-1:0];
        CFG_ROI_H:   cfg_q.roi_height       <= cfg_data_i[DIM_W-1:0];
        CFG_IMG_W:   cfg_q.image_width      <= cfg_data_i[DIM_W-1:0];
        CFG_IMG_H:   cfg_q.image_height     <= cfg_data_i[DIM_W-1:0];
        CFG_MAX_REG: cfg_q.max_regions      <= cfg_data_i[REGCNT_W-1:0];
        CFG_MAX_PIX: cfg_q.max_total_pixels <= cfg_data_i[BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  prm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (q_push),
    .cmd_o      (q_wdata),
    .q_full_i   (q_full)
  );

  prm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  prm_back #(.MAX_REGIONS(MAX_REGIONS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== design/prm_checker.sv =====
// port-level checks on the region output stream, bound to the top level
module prm_checker import prm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  logic [ID_W-1:0] exp_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_id_q <= '0;
    end else if (out_valid_o && !out_stall_i) begin
      exp_id_q <= out_data_o.last ? '0 : out_data_o.region_id + 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled item changed");

  a_dense_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.region_id == exp_id_q)
    else $error("region ids not dense within a flush");

  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.peak_count != '0 && out_data_o.box_w != '0 &&
                    out_data_o.box_h != '0)
    else $error("empty region emitted");

  a_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((DIM_W+1)'(out_data_o.box_x) + (DIM_W+1)'(out_data_o.box_w)
                     <= (DIM_W+1)'(MAX_DIM)) &&
                    ((DIM_W+1)'(out_data_o.box_y) + (DIM_W+1)'(out_data_o.box_h)
                     <= (DIM_W+1)'(MAX_DIM)))
    else $error("region leaves the image range");

endmodule

bind peak_region_merger prm_checker u_prm_checker (.*);
